/* hw/rtl/page_directory_state_tracker_assert.svh */
// Assertion macros for the page directory state tracker.
`ifndef PAGE_DIRECTORY_STATE_TRACKER_ASSERT_SVH
`define PAGE_DIRECTORY_STATE_TRACKER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off while in reset.
`define PDST_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdst assertion failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define PDST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdst assertion failed");

`else

`define PDST_ASSERT_NOW(label, ante, cons)
`define PDST_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* hw/rtl/pdst_pkg.sv */
// Shared types, codes and constants of the page directory state tracker.
package pdst_pkg;

    localparam int PAGES      = 1024;
    localparam int PAGE_BITS  = 10;
    localparam int FRAME_BITS = 24;
    localparam int GEN_BITS   = 32;
    localparam int ID_BITS    = 32;
    localparam int WAIT_BITS  = 32;
    localparam int ACT_BITS   = 3;
    localparam int ST_BITS    = 3;

    // Actions
    localparam logic [ACT_BITS-1:0] ACT_RESERVE   = 3'd0;
    localparam logic [ACT_BITS-1:0] ACT_PUBLISH   = 3'd1;
    localparam logic [ACT_BITS-1:0] ACT_RESOLVE   = 3'd2;
    localparam logic [ACT_BITS-1:0] ACT_DIRTY     = 3'd3;
    localparam logic [ACT_BITS-1:0] ACT_WRITEBACK = 3'd4;
    localparam logic [ACT_BITS-1:0] ACT_EVICT     = 3'd5;

    // Page states
    localparam logic [ST_BITS-1:0] ST_INVALID   = 3'd0;
    localparam logic [ST_BITS-1:0] ST_FETCHING  = 3'd1;
    localparam logic [ST_BITS-1:0] ST_VALID     = 3'd2;
    localparam logic [ST_BITS-1:0] ST_DIRTY     = 3'd3;
    localparam logic [ST_BITS-1:0] ST_WRITEBACK = 3'd4;

    localparam logic [GEN_BITS-1:0]  GEN_RESET  = GEN_BITS'(1);
    localparam logic [WAIT_BITS-1:0] WAIT_MAX   = '1;

    typedef struct packed {
        logic [ST_BITS-1:0]    state;
        logic [GEN_BITS-1:0]   gen;
        logic [FRAME_BITS-1:0] frame;
        logic [ID_BITS-1:0]    owner;
        logic [WAIT_BITS-1:0]  waiters;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    localparam entry_t ENTRY_RESET = '{
        state:   ST_INVALID,
        gen:     GEN_RESET,
        frame:   '0,
        owner:   '0,
        waiters: '0
    };

    typedef struct packed {
        logic                  accepted;
        logic                  owner;
        logic [GEN_BITS-1:0]   gen_out;
        logic [FRAME_BITS-1:0] frame_out;
        logic [ST_BITS-1:0]    state_out;
    } result_t;

endpackage

/* hw/rtl/pdst_if.sv */
// Handshake channels of the page directory state tracker: commands in, results out.
interface pdst_cmd_if;
    logic                               valid;
    logic                               ready;
    logic [pdst_pkg::ACT_BITS-1:0]      action;
    logic [pdst_pkg::PAGE_BITS-1:0]     page;
    logic [pdst_pkg::ID_BITS-1:0]       txn_id;
    logic [pdst_pkg::GEN_BITS-1:0]      gen_in;
    logic [pdst_pkg::FRAME_BITS-1:0]    frame_in;

    modport source (output valid, action, page, txn_id, gen_in, frame_in, input ready);
    modport sink   (input valid, action, page, txn_id, gen_in, frame_in, output ready);
endinterface

interface pdst_rsp_if;
    logic                               valid;
    logic                               ready;
    logic                               accepted;
    logic                               owner;
    logic [pdst_pkg::GEN_BITS-1:0]      gen_out;
    logic [pdst_pkg::FRAME_BITS-1:0]    frame_out;
    logic [pdst_pkg::ST_BITS-1:0]       state_out;

    modport source (output valid, accepted, owner, gen_out, frame_out, state_out, input ready);
    modport sink   (input valid, accepted, owner, gen_out, frame_out, state_out, output ready);
endinterface

/* hw/rtl/pdst_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module pdst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/page_directory_state_tracker.sv */
// Top level of the page directory state tracker: directory RAM, sequencer, result register.
//
// Page directory state tracker. Each command item passes a read step that
// reads the page's entry from the directory RAM (one synchronous read port)
// and an update step that updates the entry, writes it back and loads the
// result register. A new item is taken as soon as the previous one has ended
// its update step, even while its result still waits in the output register;
// a waiting result only stalls the next update step. After reset the block
// runs a clearing pass that writes the reset entry into every page, and it
// takes no item until that pass is done.
module page_directory_state_tracker (
    input logic      clk,
    input logic      rst_n,
    pdst_cmd_if.sink   cmd,
    pdst_rsp_if.source rsp
);

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_LOOKUP = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic [pdst_pkg::PAGE_BITS-1:0] clr_cnt_reg;
    logic [pdst_pkg::PAGE_BITS-1:0] clr_cnt_next;

    // Latched command item
    logic [pdst_pkg::ACT_BITS-1:0]   act_reg;
    logic [pdst_pkg::PAGE_BITS-1:0]  page_reg;
    logic [pdst_pkg::ID_BITS-1:0]    req_reg;
    logic [pdst_pkg::GEN_BITS-1:0]   gen_reg;
    logic [pdst_pkg::FRAME_BITS-1:0] frame_reg;

    logic                out_valid_reg;
    logic                out_valid_next;
    pdst_pkg::result_t   res_reg;
    pdst_pkg::result_t   res_calc;

    logic                            ram_we;
    logic [pdst_pkg::PAGE_BITS-1:0]  ram_waddr;
    logic [pdst_pkg::ENTRY_BITS-1:0] ram_wdata;
    logic [pdst_pkg::ENTRY_BITS-1:0] ram_rdata;
    logic                            ram_re;

    pdst_pkg::entry_t cur;
    pdst_pkg::entry_t upd;
    logic             upd_we;
    logic             match;
    logic             cmd_fire;
    logic             step;
    logic [pdst_pkg::GEN_BITS-1:0] gen_inc;

    pdst_ram #(
        .WIDTH (pdst_pkg::ENTRY_BITS),
        .DEPTH (pdst_pkg::PAGES)
    ) u_dir_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (cmd.page),
        .rdata (ram_rdata)
    );

    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign ram_re    = cmd_fire;
    // Update step runs once the result register is free or being drained
    assign step      = (state_reg == S_LOOKUP) && (!out_valid_reg || rsp.ready);

    assign cur     = pdst_pkg::entry_t'(ram_rdata);
    assign match   = (cur.gen == gen_reg);
    assign gen_inc = cur.gen + pdst_pkg::GEN_BITS'(1);

    always_comb
    begin
        upd      = cur;
        upd_we   = 1'b0;
        res_calc = '0;
        case (act_reg)
            pdst_pkg::ACT_RESERVE:
            begin
                upd_we            = 1'b1;
                res_calc.accepted = 1'b1;
                res_calc.gen_out  = cur.gen;
                if (cur.state == pdst_pkg::ST_INVALID)
                begin
                    upd.owner      = req_reg;
                    upd.waiters    = '0;
                    upd.state      = pdst_pkg::ST_FETCHING;
                    res_calc.owner = 1'b1;
                end
                else if (cur.waiters != pdst_pkg::WAIT_MAX)
                begin
                    upd.waiters = cur.waiters + pdst_pkg::WAIT_BITS'(1);
                end
            end
            pdst_pkg::ACT_PUBLISH:
            begin
                if (match && cur.state == pdst_pkg::ST_FETCHING)
                begin
                    upd.frame         = frame_reg;
                    upd.state         = pdst_pkg::ST_VALID;
                    upd_we            = 1'b1;
                    res_calc.accepted = 1'b1;
                end
            end
            pdst_pkg::ACT_RESOLVE:
            begin
                if (cur.state == pdst_pkg::ST_VALID || cur.state == pdst_pkg::ST_DIRTY)
                begin
                    res_calc.accepted  = 1'b1;
                    res_calc.gen_out   = cur.gen;
                    res_calc.frame_out = cur.frame;
                    res_calc.state_out = cur.state;
                end
            end
            pdst_pkg::ACT_DIRTY:
            begin
                if (match && cur.state == pdst_pkg::ST_VALID)
                begin
                    upd.state         = pdst_pkg::ST_DIRTY;
                    upd_we            = 1'b1;
                    res_calc.accepted = 1'b1;
                end
            end
            pdst_pkg::ACT_WRITEBACK:
            begin
                if (match && cur.state == pdst_pkg::ST_DIRTY)
                begin
                    upd.state         = pdst_pkg::ST_WRITEBACK;
                    upd_we            = 1'b1;
                    res_calc.accepted = 1'b1;
                end
            end
            pdst_pkg::ACT_EVICT:
            begin
                if (match && (cur.state == pdst_pkg::ST_VALID ||
                              cur.state == pdst_pkg::ST_WRITEBACK))
                begin
                    upd     = pdst_pkg::ENTRY_RESET;
                    // generation skips zero on wrap
                    upd.gen = (gen_inc == '0) ? pdst_pkg::GEN_RESET : gen_inc;
                    upd_we  = 1'b1;
                    res_calc.accepted = 1'b1;
                end
            end
            default:
            begin
                upd_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = page_reg;
        ram_wdata = upd;
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = pdst_pkg::ENTRY_RESET;
        end
        else if (step)
        begin
            ram_we = upd_we;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + pdst_pkg::PAGE_BITS'(1);
                if (clr_cnt_reg == pdst_pkg::PAGE_BITS'(pdst_pkg::PAGES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (step)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            act_reg   <= cmd.action;
            page_reg  <= cmd.page;
            req_reg   <= cmd.txn_id;
            gen_reg   <= cmd.gen_in;
            frame_reg <= cmd.frame_in;
        end
        if (step)
        begin
            res_reg <= res_calc;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.accepted  = res_reg.accepted;
    assign rsp.owner     = res_reg.owner;
    assign rsp.gen_out   = res_reg.gen_out;
    assign rsp.frame_out = res_reg.frame_out;
    assign rsp.state_out = res_reg.state_out;

`include "page_directory_state_tracker_assert.svh"

    `PDST_ASSERT_NOW(a_no_cmd_in_clear, state_reg == S_CLEAR, !cmd.ready)
    `PDST_ASSERT_NOW(a_we_owner, ram_we, state_reg == S_CLEAR || state_reg == S_LOOKUP)
    `PDST_ASSERT_NEXT(a_step_loads_result, step, out_valid_reg && state_reg == S_IDLE)
    `PDST_ASSERT_NOW(a_owner_implies_acc, rsp.valid && rsp.owner, rsp.accepted)

endmodule
